[rtl/disk_request_scheduler_unit_assert.svh]
// Assertion macros for the disk request scheduler
`ifndef DISK_REQUEST_SCHEDULER_UNIT_ASSERT_SVH
`define DISK_REQUEST_SCHEDULER_UNIT_ASSERT_SVH

// clocked check, masked while reset is asserted
`define DRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// implication, consequent checked in the next cycle
`define DRS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/drs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_pkg
// Shared codes and types of the disk request scheduler.
// ----------------------------------------------------------------------------
package drs_pkg;

    localparam logic [2:0] MODE_FIFO  = 3'd0;
    localparam logic [2:0] MODE_SSTF  = 3'd1;
    localparam logic [2:0] MODE_LOOK  = 3'd2;
    localparam logic [2:0] MODE_CLOOK = 3'd3;
    localparam logic [2:0] MODE_FLOOK = 3'd4;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_PICK = 1'b1;

    // candidate slots kept by the evaluator
    localparam int CAND_OLD   = 0;
    localparam int CAND_NEAR  = 1;
    localparam int CAND_UP    = 2;
    localparam int CAND_LOW   = 3;
    localparam int CAND_LEAST = 4;
    localparam int CAND_NUM   = 5;

    localparam int COUNT_OUT_BITS = 7;

    // per-cell control
    typedef struct packed {
        logic load;
        logic rotate;
        logic shift;
    } cell_ctrl_t;

    // codes above frozen look fall back to fifo
    function automatic logic [2:0] eff_mode(input logic [2:0] m);
        eff_mode = (m > MODE_FLOOK) ? MODE_FIFO : m;
    endfunction

endpackage

[rtl/drs_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_cell
// One table entry; takes its neighbour's entry on rotate or compaction.
// ----------------------------------------------------------------------------
module drs_cell #(
    parameter int ID_BITS    = 16,
    parameter int TRACK_BITS = 16
) (
    input  logic                  aclk,
    input  drs_pkg::cell_ctrl_t   ctrl,
    input  logic [ID_BITS-1:0]    load_id,
    input  logic [TRACK_BITS-1:0] load_track,
    input  logic                  load_set,
    input  logic [ID_BITS-1:0]    nbr_id,
    input  logic [TRACK_BITS-1:0] nbr_track,
    input  logic                  nbr_set,
    output logic [ID_BITS-1:0]    id,
    output logic [TRACK_BITS-1:0] track,
    output logic                  set
);

    logic [ID_BITS-1:0]    id_reg;
    logic [TRACK_BITS-1:0] track_reg;
    logic                  set_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            id_reg    <= load_id;
            track_reg <= load_track;
            set_reg   <= load_set;
        end else if (ctrl.rotate || ctrl.shift) begin
            id_reg    <= nbr_id;
            track_reg <= nbr_track;
            set_reg   <= nbr_set;
        end
    end

    assign id    = id_reg;
    assign track = track_reg;
    assign set   = set_reg;

endmodule

[rtl/drs_pick_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_pick_eval
// Watches the head cell of the rotating row, keeps the best entry per rule.
// ----------------------------------------------------------------------------
module drs_pick_eval #(
    parameter int ID_BITS    = 16,
    parameter int TRACK_BITS = 16,
    parameter int IDX_BITS   = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  clear,
    input  logic                  sample,
    input  logic                  eligible,
    input  logic [IDX_BITS-1:0]   idx,
    input  logic [ID_BITS-1:0]    cell_id,
    input  logic [TRACK_BITS-1:0] cell_track,
    input  logic                  cell_set,
    input  logic [TRACK_BITS-1:0] head,
    input  logic                  dir_up,
    input  logic [2:0]            mode,
    output logic                  found,
    output logic [IDX_BITS-1:0]   win_idx,
    output logic [ID_BITS-1:0]    win_id,
    output logic [TRACK_BITS-1:0] win_track,
    output logic                  win_set
);

    localparam int NC = drs_pkg::CAND_NUM;

    logic [NC-1:0]         has_reg;
    logic [TRACK_BITS-1:0] trk_reg [NC];
    logic [ID_BITS-1:0]    id_reg  [NC];
    logic [IDX_BITS-1:0]   idx_reg [NC];
    logic [NC-1:0]         set_reg;
    logic [TRACK_BITS-1:0] near_d_reg;

    logic [TRACK_BITS-1:0] seek_dist;
    logic                  at_or_above, at_or_below;
    logic [NC-1:0]         upd;
    int                    sel;

    always_comb begin
        at_or_above = cell_track >= head;
        at_or_below = cell_track <= head;
        seek_dist = at_or_above ? cell_track - head : head - cell_track;
        // strict compares keep the earlier entry on ties
        upd[drs_pkg::CAND_OLD]   = !has_reg[drs_pkg::CAND_OLD];
        upd[drs_pkg::CAND_NEAR]  = !has_reg[drs_pkg::CAND_NEAR] || seek_dist < near_d_reg;
        upd[drs_pkg::CAND_UP]    = at_or_above && (!has_reg[drs_pkg::CAND_UP]
                                   || cell_track < trk_reg[drs_pkg::CAND_UP]);
        upd[drs_pkg::CAND_LOW]   = at_or_below && (!has_reg[drs_pkg::CAND_LOW]
                                   || cell_track > trk_reg[drs_pkg::CAND_LOW]);
        upd[drs_pkg::CAND_LEAST] = !has_reg[drs_pkg::CAND_LEAST]
                                   || cell_track < trk_reg[drs_pkg::CAND_LEAST];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            has_reg <= '0;
        end else if (sample && eligible) begin
            has_reg <= has_reg | upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (sample && eligible) begin
            for (int c = 0; c < NC; c++) begin
                if (upd[c]) begin
                    trk_reg[c] <= cell_track;
                    id_reg[c]  <= cell_id;
                    idx_reg[c] <= idx;
                    set_reg[c] <= cell_set;
                end
            end
            if (upd[drs_pkg::CAND_NEAR]) begin
                near_d_reg <= seek_dist;
            end
        end
    end

    always_comb begin
        case (mode)
            drs_pkg::MODE_SSTF: sel = drs_pkg::CAND_NEAR;
            drs_pkg::MODE_LOOK, drs_pkg::MODE_FLOOK: begin
                if (dir_up) begin
                    sel = has_reg[drs_pkg::CAND_UP] ? drs_pkg::CAND_UP : drs_pkg::CAND_LOW;
                end else begin
                    sel = has_reg[drs_pkg::CAND_LOW] ? drs_pkg::CAND_LOW : drs_pkg::CAND_UP;
                end
            end
            drs_pkg::MODE_CLOOK: begin
                sel = has_reg[drs_pkg::CAND_UP] ? drs_pkg::CAND_UP : drs_pkg::CAND_LEAST;
            end
            default: sel = drs_pkg::CAND_OLD;
        endcase
        found     = has_reg[sel];
        win_idx   = idx_reg[sel];
        win_id    = id_reg[sel];
        win_track = trk_reg[sel];
        win_set   = set_reg[sel];
    end

endmodule

[rtl/disk_request_scheduler_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_request_scheduler_unit
// Pending disk request table with fifo, sstf, look, c-look and f-look picks.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one request: s_tuser is the command (add or pick),
//   s_tdata the request id, track, head track, direction and busy flag.
//   m_ channel returns one result per request: pick flag, picked id and
//   track, add flag and the number of requests held afterwards.
//   cfg_valid/cfg_data write the policy mode; cfg_ready is always high.
// Sequence: an add, or a pick on an empty table, goes from idle to the output
//   state, which registers the result into m_tdata. A pick on a non-empty
//   table first scans: the entries sit in a row of cells that rotates
//   once through the evaluator at the head of the row, one entry per cycle,
//   then the row closes the gap left by the chosen entry in the remove state.
// Flow: one request at a time; s_tready is high only when idle, so a new
//   request is not taken until the last one has left the output state.
// Reset: table empty, policy fifo, active set 0, no result pending.
// Stall: a result waits in the output register; one further request may be
//   taken and worked on, and its result waits until the first is taken.
// ----------------------------------------------------------------------------
`include "disk_request_scheduler_unit_assert.svh"

module disk_request_scheduler_unit #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TRACK_BITS  = 16,
    parameter int ID_BITS     = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_tuser,   // command
    // request_id, request_track, head_track, head_direction, head_busy
    input  logic [((ID_BITS + 2 * TRACK_BITS + 2 + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pick_valid, picked_id, picked_track, add_accepted, pending_count
    output logic [((2 + ID_BITS + TRACK_BITS + drs_pkg::COUNT_OUT_BITS + 7) / 8) * 8 - 1:0]
                                  m_tdata
);

    localparam int MBITS = 2 + ID_BITS + TRACK_BITS + drs_pkg::COUNT_OUT_BITS;
    localparam int MW    = ((MBITS + 7) / 8) * 8;
    localparam int IW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int OC    = drs_pkg::COUNT_OUT_BITS;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_REMOVE, ST_OUT} state_t;

    state_t                state_reg;
    logic [2:0]            mode_reg;
    logic [CW-1:0]         count_reg, cnt0_reg, cnt1_reg;
    logic                  active_reg;
    logic [IW-1:0]         step_reg;
    logic [TRACK_BITS-1:0] head_reg;
    logic                  dir_reg;
    logic                  res_pv_reg, res_acc_reg;
    logic [ID_BITS-1:0]    res_id_reg;
    logic [TRACK_BITS-1:0] res_trk_reg;
    logic                  m_valid_reg;
    logic [MW-1:0]         m_data_reg;

    logic [ID_BITS-1:0]    in_id;
    logic [TRACK_BITS-1:0] in_trk, in_head;
    logic                  in_dir, in_busy;
    logic [2:0]            mode;
    logic                  accept, add_ok, load_set, scan_start, compact;
    logic [CW-1:0]         cnt_act, cnt_oth;

    logic [ID_BITS-1:0]    cell_id  [QUEUE_DEPTH];
    logic [TRACK_BITS-1:0] cell_trk [QUEUE_DEPTH];
    logic                  cell_set [QUEUE_DEPTH];

    logic                  found, win_set, eligible;
    logic [IW-1:0]         win_idx;
    logic [ID_BITS-1:0]    win_id;
    logic [TRACK_BITS-1:0] win_trk;

    assign in_id   = s_tdata[ID_BITS-1:0];
    assign in_trk  = s_tdata[ID_BITS +: TRACK_BITS];
    assign in_head = s_tdata[ID_BITS+TRACK_BITS +: TRACK_BITS];
    assign in_dir  = s_tdata[ID_BITS+2*TRACK_BITS];
    assign in_busy = s_tdata[ID_BITS+2*TRACK_BITS+1];

    assign mode      = drs_pkg::eff_mode(mode_reg);
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign add_ok    = accept && (s_tuser == drs_pkg::CMD_ADD) && (count_reg < CW'(QUEUE_DEPTH));
    assign load_set  = (mode == drs_pkg::MODE_FLOOK && in_busy) ? !active_reg : active_reg;
    assign scan_start = accept && (s_tuser == drs_pkg::CMD_PICK) && (count_reg != '0);
    assign compact   = (state_reg == ST_REMOVE) && found;
    assign cnt_act   = active_reg ? cnt1_reg : cnt0_reg;
    assign cnt_oth   = active_reg ? cnt0_reg : cnt1_reg;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        drs_pkg::cell_ctrl_t ctrl;
        assign ctrl.load   = add_ok && (count_reg[IW-1:0] == IW'(i));
        assign ctrl.rotate = (state_reg == ST_SCAN);
        assign ctrl.shift  = compact && (IW'(i) >= win_idx);

        drs_cell #(.ID_BITS(ID_BITS), .TRACK_BITS(TRACK_BITS)) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .load_id    (in_id),
            .load_track (in_trk),
            .load_set   (load_set),
            .nbr_id     (cell_id[(i + 1) % QUEUE_DEPTH]),
            .nbr_track  (cell_trk[(i + 1) % QUEUE_DEPTH]),
            .nbr_set    (cell_set[(i + 1) % QUEUE_DEPTH]),
            .id         (cell_id[i]),
            .track      (cell_trk[i]),
            .set        (cell_set[i])
        );
    end

    // cells below the fill count hold requests, oldest in cell 0
    assign eligible = (CW'(step_reg) < count_reg)
                      && (mode != drs_pkg::MODE_FLOOK || cell_set[0] == active_reg);

    drs_pick_eval #(.ID_BITS(ID_BITS), .TRACK_BITS(TRACK_BITS), .IDX_BITS(IW)) u_eval (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear      (scan_start),
        .sample     (state_reg == ST_SCAN),
        .eligible   (eligible),
        .idx        (step_reg),
        .cell_id    (cell_id[0]),
        .cell_track (cell_trk[0]),
        .cell_set   (cell_set[0]),
        .head       (head_reg),
        .dir_up     (dir_reg),
        .mode       (mode),
        .found      (found),
        .win_idx    (win_idx),
        .win_id     (win_id),
        .win_track  (win_trk),
        .win_set    (win_set)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= drs_pkg::MODE_FIFO;
            count_reg   <= '0;
            cnt0_reg    <= '0;
            cnt1_reg    <= '0;
            active_reg  <= 1'b0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
            if (m_valid_reg && m_tready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        res_pv_reg  <= 1'b0;
                        res_id_reg  <= '0;
                        res_trk_reg <= '0;
                        res_acc_reg <= add_ok;
                        head_reg    <= in_head;
                        dir_reg     <= in_dir;
                        step_reg    <= '0;
                        if (add_ok) begin
                            count_reg <= count_reg + 1'b1;
                            if (load_set) begin
                                cnt1_reg <= cnt1_reg + 1'b1;
                            end else begin
                                cnt0_reg <= cnt0_reg + 1'b1;
                            end
                        end
                        if (scan_start) begin
                            state_reg <= ST_SCAN;
                            if (mode == drs_pkg::MODE_FLOOK && cnt_act == '0 && cnt_oth != '0) begin
                                active_reg <= !active_reg;
                            end
                        end else begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_SCAN: begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == IW'(QUEUE_DEPTH - 1)) begin
                        state_reg <= ST_REMOVE;
                    end
                end
                ST_REMOVE: begin
                    res_pv_reg  <= found;
                    res_id_reg  <= found ? win_id : '0;
                    res_trk_reg <= found ? win_trk : '0;
                    if (found) begin
                        count_reg <= count_reg - 1'b1;
                        if (win_set) begin
                            cnt1_reg <= cnt1_reg - 1'b1;
                        end else begin
                            cnt0_reg <= cnt0_reg - 1'b1;
                        end
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= MW'({OC'(count_reg), res_acc_reg, res_trk_reg,
                                            res_id_reg, res_pv_reg});
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `DRS_ASSERT(a_count_bound, count_reg <= CW'(QUEUE_DEPTH), "fill count beyond table depth")
    `DRS_ASSERT(a_set_sum, CW'(cnt0_reg + cnt1_reg) == count_reg, "set counts disagree with fill count")
    `DRS_ASSERT_NEXT(a_scan_len, state_reg == ST_SCAN && step_reg == IW'(QUEUE_DEPTH - 1),
        state_reg == ST_REMOVE, "scan did not end after a full rotation")

endmodule

[tb/tb_disk_request_scheduler_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_disk_request_scheduler_unit
// Self-checking bench for the disk request scheduler. Requests of random
// and directed content are pushed through every policy mode. A behavioural
// copy of the request table predicts each result, and the results are
// checked in order. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_disk_request_scheduler_unit;

    localparam int DEPTH  = 64;
    localparam int S_BITS = 56;
    localparam int M_BITS = 48;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic        cmd;
        logic [15:0] id;
        logic [15:0] trk;
        logic [15:0] head;
        logic        dir;
        logic        busy;
    } disk_req_t;

    typedef struct packed {
        logic        pick_ok;
        logic [15:0] id;
        logic [15:0] trk;
        logic        added;
        logic [6:0]  held;
    } disk_res_t;

    // ------------------------------------------------------------------
    class sched_scoreboard;
        logic [2:0]  mode;
        bit          used  [DEPTH];
        logic [15:0] t_id  [DEPTH];
        logic [15:0] t_trk [DEPTH];
        bit          t_set [DEPTH];
        int          age   [DEPTH];
        bit          live_set;
        int          held;
        disk_res_t   pending_res[$];
        int          errors;

        function new();
            mode = drs_pkg::MODE_FIFO;
            live_set = 0;
            held = 0;
            errors = 0;
            foreach (used[i]) used[i] = 0;
        endfunction

        // smaller key wins, older request on a tie
        function bit better(int cur, longint key_new, longint key_cur, int i);
            if (cur < 0) return 1;
            if (key_new != key_cur) return key_new < key_cur;
            return age[i] < age[cur];
        endfunction

        function int pick_slot(logic [2:0] m, logic [15:0] head, logic dir);
            int oldest, nearest, above, below, lowest;
            longint k_near, k_above, k_below, k_low, t, d;
            oldest = -1; nearest = -1; above = -1; below = -1; lowest = -1;
            k_near = 0; k_above = 0; k_below = 0; k_low = 0;
            for (int i = 0; i < DEPTH; i++) begin
                if (!used[i]) continue;
                if (m == drs_pkg::MODE_FLOOK && t_set[i] != live_set) continue;
                t = t_trk[i];
                d = (t >= head) ? t - head : head - t;
                if (oldest < 0 || age[i] < age[oldest]) oldest = i;
                if (better(nearest, d, k_near, i)) begin
                    nearest = i; k_near = d;
                end
                if (t >= head && better(above, t, k_above, i)) begin
                    above = i; k_above = t;
                end
                if (t <= head && better(below, 65535 - t, k_below, i)) begin
                    below = i; k_below = 65535 - t;
                end
                if (better(lowest, t, k_low, i)) begin
                    lowest = i; k_low = t;
                end
            end
            case (m)
                drs_pkg::MODE_SSTF: return nearest;
                drs_pkg::MODE_LOOK, drs_pkg::MODE_FLOOK: begin
                    if (dir) return (above >= 0) ? above : below;
                    return (below >= 0) ? below : above;
                end
                drs_pkg::MODE_CLOOK: return (above >= 0) ? above : lowest;
                default: return oldest;
            endcase
        endfunction

        function int count_in(bit s);
            int n;
            n = 0;
            for (int i = 0; i < DEPTH; i++) if (used[i] && t_set[i] == s) n++;
            return n;
        endfunction

        function void note_request(disk_req_t r);
            disk_res_t res;
            logic [2:0] m;
            int k, slot;
            res = '0;
            m = (mode > drs_pkg::MODE_FLOOK) ? drs_pkg::MODE_FIFO : mode;
            if (r.cmd == drs_pkg::CMD_ADD) begin
                if (held < DEPTH) begin
                    slot = 0;
                    while (used[slot]) slot++;
                    used[slot]  = 1;
                    t_id[slot]  = r.id;
                    t_trk[slot] = r.trk;
                    t_set[slot] = (m == drs_pkg::MODE_FLOOK && r.busy) ? !live_set : live_set;
                    age[slot]   = held;
                    held++;
                    res.added = 1;
                end
            end else if (held > 0) begin
                if (m == drs_pkg::MODE_FLOOK && count_in(live_set) == 0
                    && count_in(!live_set) != 0)
                    live_set = !live_set;
                k = pick_slot(m, r.head, r.dir);
                if (k >= 0) begin
                    res.pick_ok = 1;
                    res.id  = t_id[k];
                    res.trk = t_trk[k];
                    used[k] = 0;
                    for (int i = 0; i < DEPTH; i++)
                        if (used[i] && age[i] > age[k]) age[i]--;
                    held--;
                end
            end
            res.held = held[6:0];
            pending_res = {pending_res, res};
        endfunction

        function void check_result(disk_res_t got);
            disk_res_t exp_res;
            if (pending_res.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            exp_res = pending_res.pop_front();
            if (got.pick_ok !== exp_res.pick_ok || got.id !== exp_res.id ||
                got.trk !== exp_res.trk || got.added !== exp_res.added ||
                got.held !== exp_res.held) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp pv=%0d id=%h trk=%h acc=%0d cnt=%0d,",
                             exp_res.pick_ok, exp_res.id, exp_res.trk, exp_res.added,
                             exp_res.held,
                             " got pv=%0d id=%h trk=%h acc=%0d cnt=%0d",
                             got.pick_ok, got.id, got.trk, got.added, got.held);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    logic              aclk = 0;
    logic              aresetn = 0;
    logic              cfg_valid = 0;
    logic              cfg_ready;
    logic [2:0]        cfg_data = '0;
    logic              s_tvalid = 0;
    logic              s_tready;
    logic              s_tuser = 0;   // command
    // request_id, request_track, head_track, head_direction, head_busy
    logic [S_BITS-1:0] s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 0;
    // pick_valid, picked_id, picked_track, add_accepted, pending_count
    logic [M_BITS-1:0] m_tdata;

    sched_scoreboard sb = new();
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int quiet_cycles = 0;

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    disk_request_scheduler_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // result side: random back-pressure, check at the rising edge
    always @(negedge aclk)
        m_tready <= aresetn && ($urandom_range(99) >= snk_stall_pct);

    always @(posedge aclk) begin
        disk_res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.pick_ok = m_tdata[0];
            got.id      = m_tdata[16:1];
            got.trk     = m_tdata[32:17];
            got.added   = m_tdata[33];
            got.held    = m_tdata[40:34];
            sb.check_result(got);
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[disk_request_scheduler_unit] ERROR");
            $finish;
        end
    end

    task automatic send_request(disk_req_t r);
        if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid = 0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid = 1;
        s_tuser  = r.cmd;
        s_tdata  = {6'b0, r.busy, r.dir, r.head, r.trk, r.id};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        sb.note_request(r);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid = 0;
        while (sb.pending_res.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_mode(logic [2:0] m);
        drain();
        cfg_valid = 1;
        cfg_data  = m;
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
        sb.mode = m;
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    function automatic logic [15:0] rand_track();
        case ($urandom_range(3))
            0, 1: return 16'($urandom_range(15));
            2: return $urandom_range(1) ? 16'hffff : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic disk_req_t make_req(logic cmd, logic [15:0] id, logic [15:0] trk,
                                           logic [15:0] head, logic dir, logic busy);
        disk_req_t r;
        r.cmd = cmd; r.id = id; r.trk = trk; r.head = head; r.dir = dir; r.busy = busy;
        return r;
    endfunction

    function automatic disk_req_t rand_req(int add_pct);
        return make_req($urandom_range(99) < add_pct ? drs_pkg::CMD_ADD : drs_pkg::CMD_PICK,
                        16'($urandom), rand_track(), rand_track(),
                        1'($urandom), 1'($urandom));
    endfunction

    initial begin
        logic [2:0] modes[10];
        int phase_items;
        modes = '{drs_pkg::MODE_FIFO, drs_pkg::MODE_SSTF, drs_pkg::MODE_LOOK,
                  drs_pkg::MODE_CLOOK, drs_pkg::MODE_FLOOK, MODE_SPARE_LO, MODE_SPARE_HI,
                  drs_pkg::MODE_FLOOK, drs_pkg::MODE_LOOK, drs_pkg::MODE_CLOOK};
        repeat (10) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // directed: empty pick, extremes, ties, then policies on a known table
        send_request(make_req(drs_pkg::CMD_PICK, 16'h0000, 16'h0000, 16'h8000, 1'b1, 1'b0));
        send_request(make_req(drs_pkg::CMD_ADD, 16'hffff, 16'hffff, 16'h0000, 1'b0, 1'b1));
        send_request(make_req(drs_pkg::CMD_ADD, 16'h0000, 16'h0000, 16'hffff, 1'b1, 1'b0));
        send_request(make_req(drs_pkg::CMD_ADD, 16'h1234, 16'h0010, 16'h0000, 1'b0, 1'b0));
        send_request(make_req(drs_pkg::CMD_ADD, 16'h5678, 16'h0010, 16'h0000, 1'b0, 1'b0));
        send_request(make_req(drs_pkg::CMD_PICK, 16'h0000, 16'h0000, 16'h0010, 1'b1, 1'b0));
        write_mode(drs_pkg::MODE_SSTF);
        send_request(make_req(drs_pkg::CMD_PICK, 16'h0000, 16'h0000, 16'h0010, 1'b0, 1'b1));
        send_request(make_req(drs_pkg::CMD_ADD, 16'h00aa, 16'h0020, 16'h0000, 1'b0, 1'b0));
        write_mode(drs_pkg::MODE_LOOK);
        send_request(make_req(drs_pkg::CMD_PICK, 16'h0000, 16'h0000, 16'h0011, 1'b0, 1'b0));
        send_request(make_req(drs_pkg::CMD_PICK, 16'h0000, 16'h0000, 16'hffff, 1'b1, 1'b0));
        write_mode(drs_pkg::MODE_CLOOK);
        send_request(make_req(drs_pkg::CMD_ADD, 16'h00bb, 16'h0005, 16'h0000, 1'b0, 1'b0));
        send_request(make_req(drs_pkg::CMD_ADD, 16'h00cc, 16'h0003, 16'h0000, 1'b0, 1'b0));
        send_request(make_req(drs_pkg::CMD_PICK, 16'h0000, 16'h0000, 16'h0006, 1'b1, 1'b0));
        write_mode(drs_pkg::MODE_FLOOK);
        send_request(make_req(drs_pkg::CMD_ADD, 16'h00dd, 16'h0001, 16'h0000, 1'b0, 1'b1));
        send_request(make_req(drs_pkg::CMD_PICK, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0));
        send_request(make_req(drs_pkg::CMD_PICK, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0));
        send_request(make_req(drs_pkg::CMD_PICK, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0));
        send_request(make_req(drs_pkg::CMD_PICK, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0));

        // random phases: every mode, with the four idling patterns taken in turn
        for (int p = 0; p < 10; p++) begin
            write_mode(modes[p]);
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 80; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 80; end
                default: begin src_idle_pct = 38; snk_stall_pct = 38; end
            endcase
            // fill the table, push past full, then churn, then empty it
            phase_items = 0;
            while (sb.held < DEPTH && phase_items < 90) begin
                send_request(rand_req(90));
                phase_items++;
            end
            repeat (3) send_request(make_req(drs_pkg::CMD_ADD, 16'($urandom), rand_track(),
                                             16'h0000, 1'b0, 1'($urandom)));
            if (p == 4) drain();
            repeat (12) send_request(rand_req(50));
            while (sb.held > 0 && phase_items < 250) begin
                send_request(rand_req(5));
                phase_items++;
            end
            repeat (2) send_request(rand_req(0));
        end

        drain();
        repeat (100) @(negedge aclk);
        if (sb.errors == 0 && sb.pending_res.size() == 0)
            $display("[disk_request_scheduler_unit] OK");
        else
            $display("[disk_request_scheduler_unit] ERROR");
        $finish;
    end
endmodule
